/* hdl/fsweo_pkg.sv */
// Shared types and codes for the signed-entry FIFO with edit operations.
`timescale 1ns / 1ps
`default_nettype none

package fsweo_pkg;

    localparam int DATA_W = 32;
    localparam int FUNC_W = 3;

    // Operation codes carried on the func field
    localparam logic [FUNC_W-1:0] FUNC_ENQ   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DEQ   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_INS   = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CMPCT = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_CNT   = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CLR   = 3'd5;

    // What the shared match unit tests a word for
    typedef enum logic {
        MATCH_NEG = 1'b0,
        MATCH_EQ  = 1'b1
    } match_mode_t;

endpackage

`default_nettype wire

/* hdl/fifo_with_sign_edit_ops_unit.sv */
// Top level: ring-buffer FIFO of signed words with insert, compact, count and clear.
// One request is handled at a time; the next is not taken until its result is loaded.
// aresetn (synchronous, active low) clears head, occupancy, sequencer, the pending and
// insert-one flags and output valid only.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_sign_edit_ops_unit #(
    parameter  int CAPACITY = 16,
    localparam int IDX_W    = $clog2(CAPACITY),
    localparam int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [fsweo_pkg::FUNC_W-1:0] s_func,
    input  logic signed [fsweo_pkg::DATA_W-1:0] s_data_value,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [fsweo_pkg::DATA_W-1:0] m_result_value,
    output logic        [CNT_W-1:0]             m_stored_count,
    output logic                                m_was_empty,
    output logic                                m_overflowed
);
    import fsweo_pkg::*;

    localparam int SUM_W = CNT_W + 1;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,  // wait for a request word
        S_EXEC   = 7'b0000010,  // decode and run single-step operations
        S_DEQ    = 7'b0000100,  // head entry read data is back
        S_GATHER = 7'b0001000,  // copy queue in order into scratch, tally matches
        S_WRD    = 7'b0010000,  // prime the scratch read
        S_WPUT   = 7'b0100000,  // rebuild the store from scratch at index 0
        S_DONE   = 7'b1000000   // hand the result to the output register
    } state_t;

    // Entry store and scratch copy
    logic signed [DATA_W-1:0] entry_mem [CAPACITY];
    logic signed [DATA_W-1:0] scr_mem   [CAPACITY];

    state_t                   state_reg,   state_next;
    logic [FUNC_W-1:0]        func_reg,    func_next;
    logic signed [DATA_W-1:0] key_reg,     key_next;
    logic [IDX_W-1:0]         head_reg,    head_next;
    logic [CNT_W-1:0]         occ_reg,     occ_next;
    logic [CNT_W-1:0]         rd_cnt_reg,  rd_cnt_next;
    logic [CNT_W-1:0]         wr_cnt_reg,  wr_cnt_next;
    logic [CNT_W-1:0]         tally_reg,   tally_next;
    logic [CNT_W-1:0]         dst_reg,     dst_next;
    logic                     pend_reg,    pend_next;
    logic                     ins_one_reg, ins_one_next;
    logic signed [DATA_W-1:0] res_reg,     res_next;
    logic                     empty_reg,   empty_next;
    logic                     ovf_reg,     ovf_next;

    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_res_reg,   m_res_next;
    logic [CNT_W-1:0]         m_cnt_reg,   m_cnt_next;
    logic                     m_empty_reg, m_empty_next;
    logic                     m_ovf_reg,   m_ovf_next;

    // Memory ports
    logic                     entry_we;
    logic [IDX_W-1:0]         entry_waddr;
    logic signed [DATA_W-1:0] entry_wdata;
    logic [IDX_W-1:0]         entry_raddr;
    logic signed [DATA_W-1:0] entry_q;
    logic                     scr_we;
    logic [IDX_W-1:0]         scr_waddr;
    logic signed [DATA_W-1:0] scr_wdata;
    logic [IDX_W-1:0]         scr_raddr;
    logic signed [DATA_W-1:0] scr_q;

    // Shared match unit hookup
    match_mode_t              mu_mode;
    logic signed [DATA_W-1:0] mu_word;
    logic                     mu_hit;
    logic [CNT_W-1:0]         mu_tally_next;

    // Map a queue position to its storage slot, wrapping past the end of the ring
    function automatic logic [IDX_W-1:0] ring_slot(input logic [IDX_W-1:0] base,
                                                   input logic [CNT_W-1:0] pos);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(pos);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_res_reg;
    assign m_stored_count = m_cnt_reg;
    assign m_was_empty    = m_empty_reg;
    assign m_overflowed   = m_ovf_reg;

    // Count-equal compares against the key; the edit operations test the sign.
    // Gathering feeds the unit from the entry store, rebuilding from scratch.
    assign mu_mode = (func_reg == FUNC_CNT) ? MATCH_EQ : MATCH_NEG;
    assign mu_word = (state_reg == S_GATHER) ? entry_q : scr_q;

    fsweo_match #(
        .CNT_W (CNT_W)
    ) u_match (
        .mode       (mu_mode),
        .word       (mu_word),
        .key        (key_reg),
        .en         (pend_reg),
        .tally      (tally_reg),
        .hit        (mu_hit),
        .tally_next (mu_tally_next)
    );

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        key_next     = key_reg;
        head_next    = head_reg;
        occ_next     = occ_reg;
        rd_cnt_next  = rd_cnt_reg;
        wr_cnt_next  = wr_cnt_reg;
        tally_next   = tally_reg;
        dst_next     = dst_reg;
        pend_next    = pend_reg;
        ins_one_next = ins_one_reg;
        res_next     = res_reg;
        empty_next   = empty_reg;
        ovf_next     = ovf_reg;

        // Drop the output word once the consumer takes it
        m_valid_next = m_valid_reg & ~m_ready;
        m_res_next   = m_res_reg;
        m_cnt_next   = m_cnt_reg;
        m_empty_next = m_empty_reg;
        m_ovf_next   = m_ovf_reg;

        entry_we    = 1'b0;
        entry_waddr = '0;
        entry_wdata = '0;
        entry_raddr = ring_slot(head_reg, rd_cnt_reg);
        scr_we      = 1'b0;
        scr_waddr   = wr_cnt_reg[IDX_W-1:0];
        scr_wdata   = entry_q;
        scr_raddr   = rd_cnt_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    func_next  = s_func;
                    key_next   = s_data_value;
                    res_next   = '0;
                    empty_next = 1'b0;
                    ovf_next   = 1'b0;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                state_next = S_DONE;
                case (func_reg)
                    FUNC_ENQ: begin
                        if (occ_reg == CNT_W'(CAPACITY)) begin
                            ovf_next = 1'b1;
                        end else begin
                            entry_we    = 1'b1;
                            entry_waddr = ring_slot(head_reg, occ_reg);
                            entry_wdata = key_reg;
                            occ_next    = occ_reg + CNT_W'(1);
                        end
                    end
                    FUNC_DEQ: begin
                        if (occ_reg == '0) begin
                            empty_next = 1'b1;
                        end else begin
                            entry_raddr = head_reg;
                            state_next  = S_DEQ;
                        end
                    end
                    FUNC_INS, FUNC_CMPCT, FUNC_CNT: begin
                        rd_cnt_next = '0;
                        wr_cnt_next = '0;
                        tally_next  = '0;
                        pend_next   = 1'b0;
                        state_next  = S_GATHER;
                    end
                    FUNC_CLR: begin
                        head_next = '0;
                        occ_next  = '0;
                    end
                    default: begin
                        // unused codes: report occupancy only
                    end
                endcase
            end

            S_DEQ: begin
                res_next = entry_q;
                if (head_reg == IDX_W'(CAPACITY - 1)) begin
                    head_next = '0;
                end else begin
                    head_next = head_reg + IDX_W'(1);
                end
                occ_next   = occ_reg - CNT_W'(1);
                state_next = S_DONE;
            end

            S_GATHER: begin
                // Land the word read last cycle in scratch and tally it
                if (pend_reg) begin
                    scr_we      = 1'b1;
                    wr_cnt_next = wr_cnt_reg + CNT_W'(1);
                    tally_next  = mu_tally_next;
                end
                // Issue the next in-order read
                if (rd_cnt_reg != occ_reg) begin
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                    pend_next   = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if ((rd_cnt_reg == occ_reg) && !pend_reg) begin
                    if (func_reg == FUNC_CNT) begin
                        res_next   = DATA_W'(tally_reg);
                        state_next = S_DONE;
                    end else if ((func_reg == FUNC_INS) &&
                                 ((SUM_W'(occ_reg) + SUM_W'(tally_reg)) >
                                  SUM_W'(CAPACITY))) begin
                        // leave the queue untouched
                        ovf_next   = 1'b1;
                        state_next = S_DONE;
                    end else if (occ_reg == '0) begin
                        head_next  = '0;
                        state_next = S_DONE;
                    end else begin
                        rd_cnt_next  = '0;
                        dst_next     = '0;
                        ins_one_next = 1'b0;
                        state_next   = S_WRD;
                    end
                end
            end

            S_WRD: begin
                state_next = S_WPUT;
            end

            S_WPUT: begin
                if ((func_reg == FUNC_INS) && mu_hit && !ins_one_reg) begin
                    // Put a one ahead of the negative word; hold the scratch read
                    entry_we     = 1'b1;
                    entry_waddr  = dst_reg[IDX_W-1:0];
                    entry_wdata  = DATA_W'(1);
                    dst_next     = dst_reg + CNT_W'(1);
                    ins_one_next = 1'b1;
                end else begin
                    ins_one_next = 1'b0;
                    if (!((func_reg == FUNC_CMPCT) && mu_hit)) begin
                        entry_we    = 1'b1;
                        entry_waddr = dst_reg[IDX_W-1:0];
                        entry_wdata = scr_q;
                        dst_next    = dst_reg + CNT_W'(1);
                    end
                    if ((rd_cnt_reg + CNT_W'(1)) == occ_reg) begin
                        head_next  = '0;
                        occ_next   = dst_next;
                        state_next = S_DONE;
                    end else begin
                        rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                        scr_raddr   = rd_cnt_next[IDX_W-1:0];
                    end
                end
            end

            S_DONE: begin
                // Hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_cnt_next   = occ_reg;
                    m_empty_next = empty_reg;
                    m_ovf_next   = ovf_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            occ_reg     <= '0;
            pend_reg    <= 1'b0;
            ins_one_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            occ_reg     <= occ_next;
            pend_reg    <= pend_next;
            ins_one_reg <= ins_one_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload and working counters
    always_ff @(posedge aclk) begin
        func_reg    <= func_next;
        key_reg     <= key_next;
        rd_cnt_reg  <= rd_cnt_next;
        wr_cnt_reg  <= wr_cnt_next;
        tally_reg   <= tally_next;
        dst_reg     <= dst_next;
        res_reg     <= res_next;
        empty_reg   <= empty_next;
        ovf_reg     <= ovf_next;
        m_res_reg   <= m_res_next;
        m_cnt_reg   <= m_cnt_next;
        m_empty_reg <= m_empty_next;
        m_ovf_reg   <= m_ovf_next;
    end

    // Entry store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (entry_we) begin
            entry_mem[entry_waddr] <= entry_wdata;
        end
        entry_q <= entry_mem[entry_raddr];
    end

    // Scratch store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (scr_we) begin
            scr_mem[scr_waddr] <= scr_wdata;
        end
        scr_q <= scr_mem[scr_raddr];
    end

endmodule

`default_nettype wire

/* hdl/fsweo_match.sv */
// Shared compare-and-tally unit: sign test or equality test plus running count.
`timescale 1ns / 1ps
`default_nettype none

module fsweo_match #(
    parameter int CNT_W = 5
) (
    input  fsweo_pkg::match_mode_t              mode,
    input  logic signed [fsweo_pkg::DATA_W-1:0] word,
    input  logic signed [fsweo_pkg::DATA_W-1:0] key,
    input  logic                                en,
    input  logic        [CNT_W-1:0]             tally,
    output logic                                hit,
    output logic        [CNT_W-1:0]             tally_next
);
    import fsweo_pkg::*;

    always_comb begin
        if (mode == MATCH_EQ) begin
            hit = (word == key);
        end else begin
            hit = word[DATA_W-1];
        end
    end

    // Count only words that are really present this cycle
    assign tally_next = tally + CNT_W'(hit & en);

endmodule

`default_nettype wire
